[hw/rtl/imu_startup_bias_removal_macros.svh]
// Assertion macros for the RTL of the IMU startup bias removal block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef IMU_STARTUP_BIAS_REMOVAL_MACROS_SVH
`define IMU_STARTUP_BIAS_REMOVAL_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IBR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define IBR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

[hw/rtl/ibr_pkg.sv]
// Package for the IMU startup bias removal block: widths, constants, types.
// No dependencies; used by the interfaces, lanes, divider and top level.
package ibr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = SAMPLE_W + 1;
  localparam int SUM_W       = 30;
  localparam int DIFF_W      = SUM_W + 1;
  localparam int CNT_W       = 14;
  localparam int AXES        = 6;
  localparam int AX_W        = $clog2(AXES);
  localparam int SHIFT_STEPS = DIFF_W;
  localparam int STEP_W      = $clog2(SHIFT_STEPS);
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    res_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [CNT_W-1:0]    cnt_t;

  localparam cnt_t COUNT_CAP = cnt_t'(10000);
  localparam cnt_t CAL_RESET = cnt_t'(1000);
  localparam res_t OUT_MAX   = res_t'((1 << SAMPLE_W) - 1);
  localparam res_t OUT_MIN   = res_t'(-((1 << SAMPLE_W) - 1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_ACC,
    MODE_DIV,
    MODE_SUB
  } mode_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic first;
    logic last;
    logic acc;
    logic sub;
  } lane_ctrl_t;

endpackage

[hw/rtl/ibr_if.sv]
// Valid/ready channel interfaces for the IMU startup bias removal block.
// Depends on ibr_pkg for the field types.
interface ibr_in_if;
  import ibr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;

  modport source (
    output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
    input  ready
  );
  modport sink (
    input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
    output ready
  );
endinterface

interface ibr_out_if;
  import ibr_pkg::*;

  logic valid;
  logic ready;
  res_t out_gyro_x;
  res_t out_gyro_y;
  res_t out_gyro_z;
  res_t out_accel_x;
  res_t out_accel_y;
  res_t out_accel_z;
  logic calibrated;

  modport source (
    output valid, out_gyro_x, out_gyro_y, out_gyro_z,
           out_accel_x, out_accel_y, out_accel_z, calibrated,
    input  ready
  );
  modport sink (
    input  valid, out_gyro_x, out_gyro_y, out_gyro_z,
           out_accel_x, out_accel_y, out_accel_z, calibrated,
    output ready
  );
endinterface

[hw/rtl/ibr_lane.sv]
// One axis lane: bit-serial accumulate and bias subtract, LSB first.
// Holds the axis sum (bias after division). Depends on ibr_pkg.
module ibr_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  ibr_pkg::lane_ctrl_t ctrl,
  input  ibr_pkg::sample_t   sample,
  input  logic               wr_en,
  input  ibr_pkg::sum_t      wr_data,
  output ibr_pkg::sum_t      sum,
  output ibr_pkg::res_t      res
);
  import ibr_pkg::*;

  logic [SAMPLE_W-1:0] smp_r;
  sum_t                sum_r;
  logic [DIFF_W-1:0]   diff_r;
  logic                c_acc_r;
  logic                c_sub_r;

  logic a_bit, b_bit, bb_bit, c_acc_in, c_sub_in, sum_bit, d_bit;
  logic [DIFF_W-SAMPLE_W-1:0] hi;
  logic fits, is_min;

  always_comb begin
    a_bit    = smp_r[0];
    b_bit    = ctrl.last ? sum_r[SUM_W-1] : sum_r[0];
    bb_bit   = ctrl.sub & ~b_bit;
    c_acc_in = ctrl.first ? 1'b0 : c_acc_r;
    c_sub_in = ctrl.first ? ctrl.sub : c_sub_r;
    sum_bit  = ctrl.acc ? (a_bit ^ b_bit ^ c_acc_in) : sum_r[0];
    d_bit    = a_bit ^ bb_bit ^ c_sub_in;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      smp_r <= sample;
    end else if (ctrl.shift) begin
      smp_r <= {smp_r[SAMPLE_W-1], smp_r[SAMPLE_W-1:1]};
    end
    if (ctrl.shift) begin
      diff_r  <= {d_bit, diff_r[DIFF_W-1:1]};
      c_acc_r <= (a_bit & b_bit) | (a_bit & c_acc_in) | (b_bit & c_acc_in);
      c_sub_r <= (a_bit & bb_bit) | (a_bit & c_sub_in) | (bb_bit & c_sub_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (wr_en) begin
      sum_r <= wr_data;
    end else if (ctrl.shift && !ctrl.last) begin
      sum_r <= {sum_bit, sum_r[SUM_W-1:1]};
    end
  end

  // saturate the 31-bit difference to +-(2^16 - 1)
  always_comb begin
    hi     = diff_r[DIFF_W-1:SAMPLE_W];
    fits   = (&hi) | ~(|hi);
    is_min = (&hi) & ~(|diff_r[SAMPLE_W-1:0]);
    if (!fits) begin
      res = diff_r[DIFF_W-1] ? OUT_MIN : OUT_MAX;
    end else if (is_min) begin
      res = OUT_MIN;
    end else begin
      res = res_t'(diff_r[OUT_W-1:0]);
    end
  end

  assign sum = sum_r;

endmodule

[hw/rtl/ibr_div.sv]
// Shared restoring divider: signed sum / unsigned sample setting, one
// quotient bit per cycle, truncated toward zero. Depends on ibr_pkg.
module ibr_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ibr_pkg::sum_t dividend,
  input  ibr_pkg::cnt_t divisor,
  output logic          busy,
  output logic          done,
  output ibr_pkg::sum_t quotient
);
  import ibr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [SUM_W-1:0]     quo_r;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] dv;
  logic [CNT_W:0] trial_diff;
  logic           ge;

  always_comb begin
    trial      = {rem_r, quo_r[SUM_W-1]};
    dv         = {1'b0, divisor};
    trial_diff = trial - dv;
    ge         = (trial >= dv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      rem_r <= '0;
      quo_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    end else if (busy_r) begin
      rem_r <= ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (divisor == '0) begin
      quotient = '0;
    end else if (neg_r) begin
      quotient = sum_t'(-quo_r);
    end else begin
      quotient = sum_t'(quo_r);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

[hw/rtl/imu_startup_bias_removal.sv]
// Top level of the IMU startup bias removal block: control, lanes, divider.
// Depends on ibr_pkg, ibr_if, ibr_lane, ibr_div and the assertion macros.
//
// Usage: one six-axis sample enters per item on in_ch (valid/ready); one
// result per item leaves on out_ch. The first calibration_samples items are
// summed per axis and pass through raw with calibrated low. The next item
// also passes raw and turns each sum into its bias (sum / setting, truncated
// toward zero). Every later item comes out minus its bias, saturated to
// +-65535, with calibrated high. cfg_wr_en/cfg_wr_data set the sample count;
// write it only while the block is idle.
// Timing: each item runs through the bit-serial lanes (one bit per cycle of
// the 31-bit difference), then its result is loaded into the output
// register, and only then is a new item taken. The dividing item also runs
// each of the six axis sums in turn through the shared one-bit-per-cycle
// divider before its result is loaded.
// in_ch.ready is high while no item is in work; the output register holds a
// finished result while the receiver stalls, and the next item is worked
// meanwhile, waiting only to load its result.
// Reset clears the sums and the count and sets the setting to 1000.
module imu_startup_bias_removal (
  input  logic                clk,
  input  logic                rst_n,
  ibr_in_if.sink              in_ch,
  ibr_out_if.source           out_ch,
  input  logic                cfg_wr_en,
  input  ibr_pkg::cnt_t       cfg_wr_data
);
  import ibr_pkg::*;
  `include "imu_startup_bias_removal_macros.svh"

  state_t            state_r, state_nxt;
  mode_t             mode_r;
  logic [STEP_W-1:0] step_r;
  logic [AX_W-1:0]   ax_r;
  cnt_t              count_r;
  cnt_t              cal_samples_r;
  logic              out_valid_r;
  res_t              out_res_r [AXES];
  logic              out_cal_r;

  logic       in_fire;
  logic       out_free;
  logic       out_load;
  logic       div_start;
  logic       div_busy;
  logic       div_done;
  sum_t       div_q;
  lane_ctrl_t lane_ctrl;
  sample_t    in_smp   [AXES];
  sum_t       lane_sum [AXES];
  res_t       lane_res [AXES];

  assign in_smp[0] = in_ch.gyro_x;
  assign in_smp[1] = in_ch.gyro_y;
  assign in_smp[2] = in_ch.gyro_z;
  assign in_smp[3] = in_ch.accel_x;
  assign in_smp[4] = in_ch.accel_y;
  assign in_smp[5] = in_ch.accel_z;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (step_r == STEP_W'(SHIFT_STEPS - 1)) begin
          state_nxt = (mode_r == MODE_DIV) ? ST_DIVIDE : ST_DONE;
        end
      end
      ST_DIVIDE: begin
        if (div_done && ax_r == AX_W'(AXES - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = (state_r == ST_IDLE);
    lane_ctrl.load  = in_fire;
    lane_ctrl.shift = (state_r == ST_SHIFT);
    lane_ctrl.first = (step_r == '0);
    lane_ctrl.last  = (step_r == STEP_W'(SHIFT_STEPS - 1));
    lane_ctrl.acc   = (mode_r == MODE_ACC);
    lane_ctrl.sub   = (mode_r == MODE_SUB);
    div_start       = (state_r == ST_DIVIDE) & ~div_busy & ~div_done;
    out_load        = (state_r == ST_DONE) & out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_ACC;
      step_r        <= '0;
      ax_r          <= '0;
      count_r       <= '0;
      cal_samples_r <= CAL_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cal_samples_r <= cfg_wr_data;
      if (in_fire) begin
        step_r <= '0;
        if (count_r < cal_samples_r) begin
          mode_r <= MODE_ACC;
        end else if (count_r == cal_samples_r) begin
          mode_r <= MODE_DIV;
        end else begin
          mode_r <= MODE_SUB;
        end
        if (count_r < COUNT_CAP) count_r <= count_r + CNT_W'(1);
      end else if (state_r == ST_SHIFT) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (div_done) begin
        ax_r <= (ax_r == AX_W'(AXES - 1)) ? '0 : ax_r + AX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= lane_res;
      out_cal_r <= (mode_r == MODE_SUB);
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_lane
    ibr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .sample  (in_smp[k]),
      .wr_en   (div_done && ax_r == AX_W'(k)),
      .wr_data (div_q),
      .sum     (lane_sum[k]),
      .res     (lane_res[k])
    );
  end

  ibr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lane_sum[ax_r]),
    .divisor  (cal_samples_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_gyro_x  = out_res_r[0];
  assign out_ch.out_gyro_y  = out_res_r[1];
  assign out_ch.out_gyro_z  = out_res_r[2];
  assign out_ch.out_accel_x = out_res_r[3];
  assign out_ch.out_accel_y = out_res_r[4];
  assign out_ch.out_accel_z = out_res_r[5];
  assign out_ch.calibrated  = out_cal_r;

  `IBR_ASSERT_NEXT(a_accept_starts_shift, clk, rst_n, in_fire, state_r == ST_SHIFT, "item accepted but shift pass not started")
  `IBR_ASSERT_IMPL(a_div_in_divide, clk, rst_n, div_busy, state_r == ST_DIVIDE, "divider busy outside divide phase")
  `IBR_ASSERT_ALWAYS(a_count_capped, clk, rst_n, count_r <= COUNT_CAP, "sample count above cap")
  `IBR_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE), "result shown without finished item")

endmodule
